FILE: hdl/fce_pkg.sv
// ----------------------------------------------------------------------------
// fce_pkg
// Shared constants, types and register map of the feedback comb echo.
// ----------------------------------------------------------------------------
package fce_pkg;

  localparam int DELAY_DEPTH = 32768;
  localparam int SAMPLE_BITS = 16;

  localparam int ADDR_BITS  = $clog2(DELAY_DEPTH);
  localparam int CNT_BITS   = ADDR_BITS + 1;
  localparam int DELAY_BITS = 16;
  localparam int GAIN_BITS  = 15;
  localparam int GAIN_SHIFT = 15;
  localparam int GAIN_ONE   = 32768;
  localparam int GAIN_HALF  = 16384;

  localparam int DRY_BITS = SAMPLE_BITS + GAIN_BITS + 2;
  localparam int ACC_BITS = SAMPLE_BITS + GAIN_BITS + 3;

  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;

  localparam logic REG_DELAY = 1'b0;
  localparam logic REG_GAIN  = 1'b1;

  localparam logic [DELAY_BITS-1:0] DELAY_RESET = 16'd24000;
  localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = 15'd6554;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [DELAY_BITS-1:0] delay;
    logic [GAIN_BITS-1:0]  gain;
  } cfg_t;

  typedef struct packed {
    logic advance;
    logic accept;
    logic wr_en;
  } pipe_ctrl_t;

endpackage

FILE: hdl/feedback_comb_echo.sv
// ----------------------------------------------------------------------------
// feedback_comb_echo
// Recursive echo y[n] = (1-g)*x[n] + g*y[n-D] over a circular delay memory.
// ----------------------------------------------------------------------------
// Takes one sample per clock cycle while the output is not stalled; a result
// goes through the stage-one registers into the output register. The rate is
// set by the delay memory, which does one read and one write per cycle; a
// delay of one sample is served by forwarding the sample being written. The
// delay line needs no clearing pass after reset: a fill tracker makes
// unwritten entries read as zero, so samples are taken from the first cycle
// after reset.
module feedback_comb_echo (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [fce_pkg::SAMPLE_BITS-1:0] in_sample_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [fce_pkg::SAMPLE_BITS-1:0] out_sample_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fce_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [fce_pkg::PDATA_BITS-1:0]  pwdata,
  output logic [fce_pkg::PDATA_BITS-1:0]  prdata,
  output logic                            pready
);

  fce_pkg::cfg_t       cfg;
  fce_pkg::pipe_ctrl_t ctrl;
  fce_pkg::sample_t    fb;
  fce_pkg::sample_t    y;
  fce_pkg::sample_t    out_sample_r;
  logic                s1_valid_r;
  logic                out_valid_r;

  assign ctrl.advance = !(out_valid_r && out_stall);
  assign ctrl.accept  = in_valid && ctrl.advance;
  assign ctrl.wr_en   = s1_valid_r && ctrl.advance;
  assign in_stall     = !ctrl.advance;

  fce_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fce_delay_line u_delay (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .delay   (cfg.delay),
    .wr_data (y),
    .fb      (fb)
  );

  fce_mac u_mac (
    .clk    (clk),
    .accept (ctrl.accept),
    .gain   (cfg.gain),
    .x      (in_sample_in),
    .fb     (fb),
    .y      (y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (ctrl.advance) begin
      s1_valid_r  <= in_valid;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      out_sample_r <= y;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule

FILE: hdl/fce_regs.sv
// ----------------------------------------------------------------------------
// fce_regs
// APB configuration registers: echo delay and feedback gain.
// ----------------------------------------------------------------------------
module fce_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fce_pkg::PADDR_BITS-1:0]    paddr,
  input  logic [fce_pkg::PDATA_BITS-1:0]    pwdata,
  output logic [fce_pkg::PDATA_BITS-1:0]    prdata,
  output logic                              pready,
  output fce_pkg::cfg_t                     cfg
);

  logic [fce_pkg::DELAY_BITS-1:0] delay_r;
  logic [fce_pkg::GAIN_BITS-1:0]  gain_r;
  logic                           wr_stb;

  assign pready = 1'b1;
  assign wr_stb = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= fce_pkg::DELAY_RESET;
      gain_r  <= fce_pkg::GAIN_RESET;
    end else if (wr_stb) begin
      unique case (paddr[2])
        fce_pkg::REG_DELAY: delay_r <= pwdata[fce_pkg::DELAY_BITS-1:0];
        fce_pkg::REG_GAIN:  gain_r  <= pwdata[fce_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      fce_pkg::REG_DELAY: prdata = fce_pkg::PDATA_BITS'(delay_r);
      fce_pkg::REG_GAIN:  prdata = fce_pkg::PDATA_BITS'(gain_r);
      default:            prdata = '0;
    endcase
  end

  assign cfg.delay = delay_r;
  assign cfg.gain  = gain_r;

endmodule

FILE: hdl/fce_delay_line.sv
// ----------------------------------------------------------------------------
// fce_delay_line
// Circular delay memory of past outputs: read address generation, fill
// tracking, and forwarding of the write that coincides with a read.
// ----------------------------------------------------------------------------
module fce_delay_line (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fce_pkg::pipe_ctrl_t             ctrl,
  input  logic [fce_pkg::DELAY_BITS-1:0]  delay,
  input  fce_pkg::sample_t                wr_data,
  output fce_pkg::sample_t                fb
);

  localparam int CMP_BITS = (fce_pkg::CNT_BITS > fce_pkg::DELAY_BITS) ?
                            fce_pkg::CNT_BITS : fce_pkg::DELAY_BITS;
  localparam logic [CMP_BITS-1:0] DEPTH_CMP = CMP_BITS'(fce_pkg::DELAY_DEPTH);
  localparam logic [fce_pkg::CNT_BITS-1:0] DEPTH_CNT =
    fce_pkg::CNT_BITS'(fce_pkg::DELAY_DEPTH);
  localparam logic [fce_pkg::ADDR_BITS-1:0] LAST_ADDR =
    fce_pkg::ADDR_BITS'(fce_pkg::DELAY_DEPTH - 1);

  fce_pkg::sample_t mem [fce_pkg::DELAY_DEPTH];

  logic [fce_pkg::ADDR_BITS-1:0] wp_r;
  logic [fce_pkg::ADDR_BITS-1:0] wp_nxt;
  logic [fce_pkg::ADDR_BITS-1:0] wr_addr_r;
  logic                          full_r;
  logic                          hit_r;
  logic                          rd_valid_r;
  fce_pkg::sample_t              q_r;
  fce_pkg::sample_t              fwd_r;

  logic [CMP_BITS-1:0]           d_ext;
  logic [CMP_BITS-1:0]           d_sel;
  logic [fce_pkg::CNT_BITS-1:0]  d_cnt;
  logic [fce_pkg::CNT_BITS-1:0]  wp_ext;
  logic [fce_pkg::CNT_BITS-1:0]  rd_full;
  logic [fce_pkg::ADDR_BITS-1:0] rd_addr;
  logic                          rd_valid;
  logic                          hit;

  always_comb begin
    d_ext   = CMP_BITS'(delay);
    d_sel   = (d_ext == '0 || d_ext > DEPTH_CMP) ? DEPTH_CMP : d_ext;
    d_cnt   = d_sel[fce_pkg::CNT_BITS-1:0];
    wp_ext  = {1'b0, wp_r};
    rd_full = (wp_ext >= d_cnt) ? (wp_ext - d_cnt) : (wp_ext + DEPTH_CNT - d_cnt);
    rd_addr = rd_full[fce_pkg::ADDR_BITS-1:0];
    // entries are filled in address order, so unwritten ones read as zero
    rd_valid = full_r || (rd_addr < wp_r);
    hit      = ctrl.wr_en && (wr_addr_r == rd_addr);
    wp_nxt   = (wp_r == LAST_ADDR) ? '0 : wp_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      full_r     <= 1'b0;
      hit_r      <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctrl.accept) begin
        wp_r <= wp_nxt;
        if (wp_r == LAST_ADDR) begin
          full_r <= 1'b1;
        end
      end
      if (ctrl.advance) begin
        hit_r      <= hit;
        rd_valid_r <= rd_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      wr_addr_r <= wp_r;
    end
    if (ctrl.wr_en) begin
      fwd_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      q_r <= mem[rd_addr];
    end
  end

  assign fb = !rd_valid_r ? '0 : (hit_r ? fwd_r : q_r);

endmodule

FILE: hdl/fce_mac.sv
// ----------------------------------------------------------------------------
// fce_mac
// Dry and feedback products, rounding and saturation of the output sample.
// ----------------------------------------------------------------------------
module fce_mac (
  input  logic                           clk,
  input  logic                           accept,
  input  logic [fce_pkg::GAIN_BITS-1:0]  gain,
  input  fce_pkg::sample_t               x,
  input  fce_pkg::sample_t               fb,
  output fce_pkg::sample_t               y
);

  localparam int S   = fce_pkg::SAMPLE_BITS;
  localparam int ACC = fce_pkg::ACC_BITS;
  localparam logic signed [ACC-1:0] SMAX = {{(ACC-S+1){1'b0}}, {(S-1){1'b1}}};
  localparam logic signed [ACC-1:0] SMIN = {{(ACC-S+1){1'b1}}, {(S-1){1'b0}}};
  localparam logic signed [ACC-1:0] HALF = ACC'(fce_pkg::GAIN_HALF);

  logic [fce_pkg::GAIN_BITS:0]             dry_gain;
  logic signed [fce_pkg::DRY_BITS-1:0]     dry_nxt;
  logic signed [fce_pkg::DRY_BITS-1:0]     dry_r;
  logic signed [fce_pkg::DRY_BITS-2:0]     wet;
  logic signed [ACC-1:0]                   acc;
  logic signed [ACC-1:0]                   acc_sh;

  assign dry_gain = (fce_pkg::GAIN_BITS+1)'(fce_pkg::GAIN_ONE) - {1'b0, gain};
  assign dry_nxt  = $signed({1'b0, dry_gain}) * x;

  always_ff @(posedge clk) begin
    if (accept) begin
      dry_r <= dry_nxt;
    end
  end

  always_comb begin
    wet    = $signed({1'b0, gain}) * fb;
    acc    = dry_r + wet + HALF;
    acc_sh = acc >>> fce_pkg::GAIN_SHIFT;
    if (acc_sh > SMAX) begin
      y = SMAX[S-1:0];
    end else if (acc_sh < SMIN) begin
      y = SMIN[S-1:0];
    end else begin
      y = acc_sh[S-1:0];
    end
  end

endmodule

FILE: sim/tb_feedback_comb_echo.sv
// ----------------------------------------------------------------------------
// tb_feedback_comb_echo
// Self-checking bench for the feedback comb echo.
// ----------------------------------------------------------------------------
// A queue of samples feeds a clocked driver; a clocked monitor compares each
// echoed sample with a local model of the comb filter that keeps its own
// delay line, write pointer, delay and gain. Directed samples hit the sample
// extremes and the delay corner cases: one-sample delay, zero delay, a delay
// past the line depth, and the full depth. Random phases then vary delay,
// gain, sender gaps and receiver stalls, and one receiver hold-off backs the
// pipeline up into the input.
// ----------------------------------------------------------------------------
module tb_feedback_comb_echo;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_LEN    = 300;
  localparam int PHASE_ITEMS = 200;
  localparam int MAX_REPORTS = 10;

  localparam logic [fce_pkg::PADDR_BITS-1:0] ADDR_DELAY =
    fce_pkg::PADDR_BITS'(4 * int'(fce_pkg::REG_DELAY));
  localparam logic [fce_pkg::PADDR_BITS-1:0] ADDR_GAIN  =
    fce_pkg::PADDR_BITS'(4 * int'(fce_pkg::REG_GAIN));

  localparam longint SAMPLE_HI = (longint'(1) <<< (fce_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_LO = -(longint'(1) <<< (fce_pkg::SAMPLE_BITS - 1));

  logic                           clk          = 1'b0;
  logic                           rst_n        = 1'b0;
  logic                           in_valid     = 1'b0;
  logic                           in_stall;
  fce_pkg::sample_t               in_sample_in = '0;
  logic                           out_valid;
  logic                           out_stall    = 1'b0;
  fce_pkg::sample_t               out_sample_out;
  logic                           psel         = 1'b0;
  logic                           penable      = 1'b0;
  logic                           pwrite       = 1'b0;
  logic [fce_pkg::PADDR_BITS-1:0] paddr        = '0;
  logic [fce_pkg::PDATA_BITS-1:0] pwdata       = '0;
  logic [fce_pkg::PDATA_BITS-1:0] prdata;
  logic                           pready;

  feedback_comb_echo dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // comb filter model state
  fce_pkg::sample_t               echo_line [fce_pkg::DELAY_DEPTH];
  logic [fce_pkg::ADDR_BITS-1:0]  line_wr_ptr;
  logic [fce_pkg::DELAY_BITS-1:0] cur_delay;
  logic [fce_pkg::GAIN_BITS-1:0]  cur_gain;

  fce_pkg::sample_t sample_backlog[$];
  fce_pkg::sample_t expected_echo[$];

  int idle_pct       = 0;
  int stall_pct      = 0;
  int hold_left      = 0;
  logic hold_start   = 1'b0;
  int samples_queued = 0;
  int samples_sent   = 0;
  int echoes_checked = 0;
  int held_cycles    = 0;
  int regs_written   = 0;
  int errors         = 0;
  int cycle_count    = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic fce_pkg::sample_t predict_echo(fce_pkg::sample_t x);
    logic [fce_pkg::CNT_BITS-1:0]  span;
    logic [fce_pkg::ADDR_BITS-1:0] rd_ptr;
    longint acc;
    longint y;
    span = (cur_delay == 0 || cur_delay > fce_pkg::DELAY_DEPTH) ?
           fce_pkg::CNT_BITS'(fce_pkg::DELAY_DEPTH) : fce_pkg::CNT_BITS'(cur_delay);
    rd_ptr = line_wr_ptr - span[fce_pkg::ADDR_BITS-1:0];
    acc = longint'(fce_pkg::GAIN_ONE - int'(cur_gain)) * longint'(x)
        + longint'(int'(cur_gain)) * longint'(echo_line[rd_ptr]) + fce_pkg::GAIN_HALF;
    y = acc >>> fce_pkg::GAIN_SHIFT;
    if (y > SAMPLE_HI) y = SAMPLE_HI;
    if (y < SAMPLE_LO) y = SAMPLE_LO;
    echo_line[line_wr_ptr] = fce_pkg::sample_t'(y);
    line_wr_ptr = line_wr_ptr + 1'b1;
    return fce_pkg::sample_t'(y);
  endfunction

  function automatic fce_pkg::sample_t pick_sample();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return fce_pkg::sample_t'(SAMPLE_HI);
          1: return fce_pkg::sample_t'(SAMPLE_LO);
          2: return '0;
          default: return '1;
        endcase
      end
      1: return fce_pkg::sample_t'($urandom_range(15)) - fce_pkg::sample_t'(8);
      default: return fce_pkg::sample_t'($urandom);
    endcase
  endfunction

  task automatic report_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // driver: one sample offered at a time, held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_stall) held_cycles++;
      if (!in_valid || !in_stall) begin
        if (in_valid) begin
          expected_echo.push_back(predict_echo(in_sample_in));
          samples_sent++;
        end
        if (sample_backlog.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_valid     <= 1'b1;
          in_sample_in <= sample_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transfer, drive random stalls
  always @(posedge clk) begin
    fce_pkg::sample_t want;
    if (rst_n && out_valid && !out_stall) begin
      echoes_checked++;
      if (expected_echo.size() == 0) begin
        report_error($sformatf("unexpected result %0d", out_sample_out));
      end else begin
        want = expected_echo.pop_front();
        if (out_sample_out !== want)
          report_error($sformatf("result %0d: sample_out expected %0d, got %0d",
                                 echoes_checked, want, out_sample_out));
      end
    end
    out_stall <= rst_n && (hold_left > 0 || $urandom_range(99) < stall_pct);
  end

  // receiver hold-off counter
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_echo.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [fce_pkg::PADDR_BITS-1:0] addr,
                           logic [fce_pkg::PDATA_BITS-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_DELAY) cur_delay = data[fce_pkg::DELAY_BITS-1:0];
    else cur_gain = data[fce_pkg::GAIN_BITS-1:0];
    regs_written++;
  endtask

  task automatic set_echo(int delay, int gain);
    write_reg(ADDR_DELAY, fce_pkg::PDATA_BITS'(delay));
    write_reg(ADDR_GAIN, fce_pkg::PDATA_BITS'(gain));
  endtask

  task automatic set_idle(int send_gap, int recv_stall);
    idle_pct  <= send_gap;
    stall_pct <= recv_stall;
  endtask

  task automatic push_sample(fce_pkg::sample_t s);
    sample_backlog.push_back(s);
    samples_queued++;
  endtask

  task automatic queue_samples(int n);
    for (int i = 0; i < n; i++) push_sample(pick_sample());
  endtask

  task automatic drain();
    while (samples_sent != samples_queued || expected_echo.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int d;
    int g;
    for (int i = 0; i < fce_pkg::DELAY_DEPTH; i++) echo_line[i] = '0;
    line_wr_ptr = '0;
    cur_delay   = fce_pkg::DELAY_RESET;
    cur_gain    = fce_pkg::GAIN_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings
    push_sample(fce_pkg::sample_t'(SAMPLE_HI));
    push_sample(fce_pkg::sample_t'(SAMPLE_LO));
    push_sample('0);
    push_sample('1);
    drain();

    // one-sample delay, strongest feedback: back-to-back forwarding
    set_echo(1, 32767);
    push_sample(fce_pkg::sample_t'(SAMPLE_HI));
    push_sample(fce_pkg::sample_t'(SAMPLE_LO));
    push_sample(fce_pkg::sample_t'(1));
    push_sample('1);
    push_sample(fce_pkg::sample_t'(16'h5555));
    push_sample(fce_pkg::sample_t'(16'haaaa));
    drain();

    // zero delay means full depth; no feedback passes input through
    set_echo(0, 0);
    push_sample(fce_pkg::sample_t'(SAMPLE_HI));
    push_sample(fce_pkg::sample_t'(SAMPLE_LO));
    push_sample('0);
    drain();

    // delay past the line depth
    set_echo(65535, 16384);
    push_sample(fce_pkg::sample_t'(SAMPLE_LO));
    push_sample(fce_pkg::sample_t'(SAMPLE_HI));
    drain();

    // exact full depth
    set_echo(fce_pkg::DELAY_DEPTH, 32767);
    push_sample(fce_pkg::sample_t'(SAMPLE_HI));
    push_sample('1);
    drain();

    set_echo(2, 1);
    push_sample(fce_pkg::sample_t'(SAMPLE_HI));
    push_sample(fce_pkg::sample_t'(SAMPLE_LO));
    push_sample(fce_pkg::sample_t'(SAMPLE_HI));
    push_sample(fce_pkg::sample_t'(SAMPLE_LO));
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin d = 1;     g = 32767; end
        1: begin d = 65535; g = 16384; end
        2: begin d = fce_pkg::DELAY_DEPTH + 1; g = 0; end
        3: begin d = 0;     g = 32767; end
        4: begin d = 2;     g = 1; end
        5: begin d = fce_pkg::DELAY_DEPTH - 1; g = $urandom_range(32767); end
        6: begin d = $urandom_range(fce_pkg::DELAY_DEPTH, 1); g = $urandom_range(32767); end
        default: begin d = $urandom_range(65535); g = $urandom_range(32767); end
      endcase
      set_echo(d, g);
      case (p % 4)
        0: set_idle(0, 0);
        1: set_idle(80, 0);
        2: set_idle(0, 80);
        default: set_idle(31, 31);
      endcase
      queue_samples(PHASE_ITEMS);
      if (p == 0) begin
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      drain();
    end

    errors += expected_echo.size();
    $display("Echo run: %0d samples in, %0d results checked, %0d register writes",
             samples_sent, echoes_checked, regs_written);
    $display("Delay corners, gain extremes, gaps and stalls; input held on %0d cycles; %0d errors",
             held_cycles, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
